// ----- rtl/rtsf_pkg.sv -----
package rtsf_pkg;

	// sample and result field widths
	localparam int SAMPLE_W  = 12;
	localparam int OUTCOME_W = 2;
	localparam int THR_W     = 13;

	localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'd4095;

	// shared divider operand widths: dividend covers (raw - lo) * smax
	localparam int NUM_W = 2 * SAMPLE_W;
	localparam int DEN_W = SAMPLE_W;

	// configuration port
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 24;

	localparam logic [CFG_IDX_W-1:0] REG_CAL_X_LOW    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_X_HIGH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_Y_LOW    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_Y_HIGH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GHOST_CENTER = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GHOST_RADIUS = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_THR    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ORIENT       = 3'd7;

	localparam logic [SAMPLE_W-1:0] CAL_LOW_RST  = 12'd200;
	localparam logic [SAMPLE_W-1:0] CAL_HIGH_RST = 12'd3900;
	localparam logic [THR_W-1:0]    THR_RST      = 13'd400;

	// orientation flag bits
	localparam int OR_SWAP  = 0;
	localparam int OR_INV_X = 1;
	localparam int OR_INV_Y = 2;
	localparam int OR_RAW   = 3;

	// outcome codes
	localparam logic [OUTCOME_W-1:0] OUT_TOUCH = 2'd0;
	localparam logic [OUTCOME_W-1:0] OUT_LOW   = 2'd1;
	localparam logic [OUTCOME_W-1:0] OUT_GHOST = 2'd2;

	// accumulator controls from the sequencer
	typedef struct packed {
		logic take;       // sample transfer this cycle
		logic clr_press;  // clear Z1/Z2 totals
		logic clr_axis;   // clear running sum/min/max
		logic clr_index;  // restart the frame
	} acc_ctl_t;

endpackage

// ----- rtl/rtsf_accum.sv -----
module rtsf_accum #(
	parameter int SAMPLES_PER_AXIS = 30,
	parameter int PRESSURE_READS   = 4
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  rtsf_pkg::acc_ctl_t                    ctl,
	input  logic [rtsf_pkg::SAMPLE_W-1:0]         sample,
	output logic [$clog2(2*PRESSURE_READS+2*SAMPLES_PER_AXIS+1)-1:0] idx,
	output logic [rtsf_pkg::SAMPLE_W+$clog2(PRESSURE_READS+1)-1:0]    z1_total,
	output logic [rtsf_pkg::SAMPLE_W+$clog2(PRESSURE_READS+1)-1:0]    z2_total,
	output logic [rtsf_pkg::SAMPLE_W+$clog2(SAMPLES_PER_AXIS+1)-1:0]  kept
);

	localparam int Y_END = 2 * PRESSURE_READS + 2 * SAMPLES_PER_AXIS;
	localparam int IDX_W = $clog2(Y_END + 1);
	localparam int Z_W   = rtsf_pkg::SAMPLE_W + $clog2(PRESSURE_READS + 1);
	localparam int AX_W  = rtsf_pkg::SAMPLE_W + $clog2(SAMPLES_PER_AXIS + 1);

	localparam logic [IDX_W-1:0] Z1_END = IDX_W'(PRESSURE_READS);
	localparam logic [IDX_W-1:0] Z2_END = IDX_W'(2 * PRESSURE_READS);

	logic [IDX_W-1:0]              idx_q;
	logic [Z_W-1:0]                z1_q, z2_q;
	logic [AX_W-1:0]               tot_q;
	logic [rtsf_pkg::SAMPLE_W-1:0] least_q, most_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			z1_q    <= '0;
			z2_q    <= '0;
			tot_q   <= '0;
			least_q <= rtsf_pkg::FULL_SCALE;
			most_q  <= '0;
		end else begin
			if (ctl.take) begin
				idx_q <= idx_q + IDX_W'(1);
				if (idx_q < Z1_END) begin
					z1_q <= z1_q + Z_W'(sample);
				end else if (idx_q < Z2_END) begin
					z2_q <= z2_q + Z_W'(sample);
				end else begin
					tot_q <= tot_q + AX_W'(sample);
					if (sample < least_q) least_q <= sample;
					if (sample > most_q)  most_q  <= sample;
				end
			end
			if (ctl.clr_press) begin
				z1_q <= '0;
				z2_q <= '0;
			end
			if (ctl.clr_axis) begin
				tot_q   <= '0;
				least_q <= rtsf_pkg::FULL_SCALE;
				most_q  <= '0;
			end
			if (ctl.clr_index) idx_q <= '0;
		end
	end

	assign idx      = idx_q;
	assign z1_total = z1_q;
	assign z2_total = z2_q;
	// trimmed sum: one minimum and one maximum dropped
	assign kept     = tot_q - AX_W'(least_q) - AX_W'(most_q);

endmodule

// ----- rtl/rtsf_div.sv -----
module rtsf_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [rtsf_pkg::NUM_W-1:0]     num,
	input  logic [rtsf_pkg::DEN_W-1:0]     den,
	output logic                           busy,
	output logic                           done,
	output logic [rtsf_pkg::NUM_W-1:0]     quo
);

	localparam int NUM_W = rtsf_pkg::NUM_W;
	localparam int DEN_W = rtsf_pkg::DEN_W;
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q, den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;
	logic [DEN_W:0]   trial;
	logic             fits;
	logic [DEN_W:0]   diff;

	// restoring divide, one quotient bit per cycle, dividend shifts out MSB first
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a running divide");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q < den_q))
		else $error("partial remainder not below divisor");

endmodule

// ----- rtl/resistive_touch_sample_filter.sv -----
// Resistive touch sample filter.
// s_* stream: one 12-bit ADC conversion per transfer, in the fixed frame order
//   PRESSURE_READS x Z1, PRESSURE_READS x Z2, SAMPLES_PER_AXIS x X, then Y.
// m_* stream: one result per failed pressure gate and one per complete frame.
//   tuser carries touched and outcome, tdata the position.
// cfg_*: plain register writes, taken at any edge with cfg_we high.
// Throughput: one sample per cycle while samples are being summed. At the three
//   phase ends the sequencer holds s_tready low and reuses one restoring divider
//   (NUM_W = 24 bits, one quotient bit per cycle) and one registered 12x12
//   multiplier:
//     end of Z2: two divides;
//     end of X : one divide;
//     end of Y : one divide, the null zone squares on the multiplier, and up
//                to two mapping divides.
// Reset: calibration registers take their defaults, the frame restarts at Z1,
//   no result is pending.
// Stall: a finished result sits in the output register; sampling continues.
//   A second result waits in the sequencer until the first transfer completes.
module resistive_touch_sample_filter #(
	parameter int SAMPLES_PER_AXIS = 30,
	parameter int PRESSURE_READS   = 4,
	parameter int SCREEN_WIDTH     = 320,
	parameter int SCREEN_HEIGHT    = 240
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input sample stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [15:0]                       s_tdata,   // [11:0] adc_sample
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [23:0]                       m_tdata,   // [11:0] pos_x, [23:12] pos_y
	output logic [2:0]                        m_tuser,   // [0] touched, [2:1] outcome
	// configuration
	input  logic                              cfg_we,
	input  logic [rtsf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rtsf_pkg::CFG_W-1:0]        cfg_data
);

	localparam int SW    = rtsf_pkg::SAMPLE_W;
	localparam int NUM_W = rtsf_pkg::NUM_W;
	localparam int DEN_W = rtsf_pkg::DEN_W;
	localparam int Z2_END = 2 * PRESSURE_READS;
	localparam int X_END  = Z2_END + SAMPLES_PER_AXIS;
	localparam int Y_END  = X_END + SAMPLES_PER_AXIS;
	localparam int IDX_W  = $clog2(Y_END + 1);
	localparam int Z_W    = SW + $clog2(PRESSURE_READS + 1);
	localparam int AX_W   = SW + $clog2(SAMPLES_PER_AXIS + 1);

	localparam logic [SW-1:0]    WMAX = SW'(SCREEN_WIDTH - 1);
	localparam logic [SW-1:0]    HMAX = SW'(SCREEN_HEIGHT - 1);
	localparam logic [DEN_W-1:0] PRESS_DIV = DEN_W'(PRESSURE_READS);
	localparam logic [DEN_W-1:0] TRIM_DIV  = DEN_W'(SAMPLES_PER_AXIS - 2);

	// sequencer states
	localparam logic [3:0] ST_ACC    = 4'd0;
	localparam logic [3:0] ST_ZDIV1  = 4'd1;
	localparam logic [3:0] ST_ZDIV2  = 4'd2;
	localparam logic [3:0] ST_GATE   = 4'd3;
	localparam logic [3:0] ST_XDIV   = 4'd4;
	localparam logic [3:0] ST_YDIV   = 4'd5;
	localparam logic [3:0] ST_SQX    = 4'd6;
	localparam logic [3:0] ST_SQY    = 4'd7;
	localparam logic [3:0] ST_SQR    = 4'd8;
	localparam logic [3:0] ST_CMP    = 4'd9;
	localparam logic [3:0] ST_MAP    = 4'd10;
	localparam logic [3:0] ST_MAPDIV = 4'd11;
	localparam logic [3:0] ST_EMIT   = 4'd12;

	// configuration registers
	logic [SW-1:0]              cal_x_low_q, cal_x_high_q, cal_y_low_q, cal_y_high_q;
	logic [2*SW-1:0]            ghost_center_q;
	logic [SW-1:0]              ghost_radius_q;
	logic [rtsf_pkg::THR_W-1:0] thr_q;
	logic [3:0]                 orient_q;

	// sequencer and datapath
	logic [3:0]                 state_q;
	logic                       div_start_q;
	logic                       axis_q;       // 0: column, 1: row
	logic [SW-1:0]              avg1_q, x_avg_q, y_avg_q;
	logic [rtsf_pkg::THR_W-1:0] gate_q;
	logic [2*SW-1:0]            prod_q;
	logic [2*SW:0]              sq_sum_q;
	logic                       res_touched_q;
	logic [rtsf_pkg::OUTCOME_W-1:0] res_outcome_q;
	logic [SW-1:0]              res_x_q, res_y_q;

	// output register
	logic                       out_valid_q;
	logic                       out_touched_q;
	logic [rtsf_pkg::OUTCOME_W-1:0] out_outcome_q;
	logic [SW-1:0]              out_x_q, out_y_q;

	rtsf_pkg::acc_ctl_t         ctl;
	logic [IDX_W-1:0]           idx, pos_next;
	logic [Z_W-1:0]             z1_total, z2_total;
	logic [AX_W-1:0]            kept;
	logic                       accept;
	logic                       div_busy, div_done;
	logic [NUM_W-1:0]           div_num, div_quo;
	logic [DEN_W-1:0]           div_den;
	logic [SW-1:0]              quo_s;
	logic [SW:0]                dx, dy;
	logic [SW-1:0]              adx, ady;
	logic [SW-1:0]              mul_a, mul_b;
	logic                       swap;
	logic [SW-1:0]              map_raw, map_lo, map_hi, map_smax, map_val, map_out;
	logic                       map_inv, map_le_lo, map_ge_hi;
	logic                       load_out;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_ACC);
	assign pos_next = idx + IDX_W'(1);
	assign quo_s    = div_quo[SW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_x_low_q    <= rtsf_pkg::CAL_LOW_RST;
			cal_x_high_q   <= rtsf_pkg::CAL_HIGH_RST;
			cal_y_low_q    <= rtsf_pkg::CAL_LOW_RST;
			cal_y_high_q   <= rtsf_pkg::CAL_HIGH_RST;
			ghost_center_q <= '0;
			ghost_radius_q <= '0;
			thr_q          <= rtsf_pkg::THR_RST;
			orient_q       <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				rtsf_pkg::REG_CAL_X_LOW:    cal_x_low_q    <= cfg_data[SW-1:0];
				rtsf_pkg::REG_CAL_X_HIGH:   cal_x_high_q   <= cfg_data[SW-1:0];
				rtsf_pkg::REG_CAL_Y_LOW:    cal_y_low_q    <= cfg_data[SW-1:0];
				rtsf_pkg::REG_CAL_Y_HIGH:   cal_y_high_q   <= cfg_data[SW-1:0];
				rtsf_pkg::REG_GHOST_CENTER: ghost_center_q <= cfg_data[2*SW-1:0];
				rtsf_pkg::REG_GHOST_RADIUS: ghost_radius_q <= cfg_data[SW-1:0];
				rtsf_pkg::REG_PRESS_THR:    thr_q          <= cfg_data[rtsf_pkg::THR_W-1:0];
				rtsf_pkg::REG_ORIENT:       orient_q       <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// accumulator controls
	always_comb begin
		ctl.take      = accept;
		ctl.clr_press = (state_q == ST_ZDIV2) && div_done;
		ctl.clr_axis  = div_done && ((state_q == ST_ZDIV2) || (state_q == ST_XDIV) ||
		                             (state_q == ST_YDIV));
		ctl.clr_index = ((state_q == ST_GATE) && (gate_q < thr_q)) ||
		                ((state_q == ST_YDIV) && div_done);
	end

	rtsf_accum #(
		.SAMPLES_PER_AXIS(SAMPLES_PER_AXIS),
		.PRESSURE_READS  (PRESSURE_READS)
	) u_accum (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.sample  (s_tdata[SW-1:0]),
		.idx     (idx),
		.z1_total(z1_total),
		.z2_total(z2_total),
		.kept    (kept)
	);

	// mapping operands; swap exchanges the raw axes and their calibration pairs
	assign swap = orient_q[rtsf_pkg::OR_SWAP];
	always_comb begin
		if (!axis_q) begin
			map_raw  = swap ? y_avg_q : x_avg_q;
			map_lo   = swap ? cal_y_low_q : cal_x_low_q;
			map_hi   = swap ? cal_y_high_q : cal_x_high_q;
			map_smax = WMAX;
			map_inv  = orient_q[rtsf_pkg::OR_INV_X];
		end else begin
			map_raw  = swap ? x_avg_q : y_avg_q;
			map_lo   = swap ? cal_x_low_q : cal_y_low_q;
			map_hi   = swap ? cal_x_high_q : cal_y_high_q;
			map_smax = HMAX;
			map_inv  = orient_q[rtsf_pkg::OR_INV_Y];
		end
	end
	assign map_le_lo = map_raw <= map_lo;
	assign map_ge_hi = map_raw >= map_hi;
	// clamped ends in ST_MAP, divider quotient in ST_MAPDIV
	assign map_val = (state_q == ST_MAPDIV) ? quo_s : (map_le_lo ? '0 : map_smax);
	assign map_out = map_inv ? (map_smax - map_val) : map_val;

	// null zone distances
	assign dx  = {1'b0, x_avg_q} - {1'b0, ghost_center_q[SW-1:0]};
	assign dy  = {1'b0, y_avg_q} - {1'b0, ghost_center_q[2*SW-1:SW]};
	assign adx = dx[SW] ? SW'(-dx) : dx[SW-1:0];
	assign ady = dy[SW] ? SW'(-dy) : dy[SW-1:0];

	// shared multiplier operands
	always_comb begin
		case (state_q)
			ST_SQX: begin
				mul_a = adx;
				mul_b = adx;
			end
			ST_SQY: begin
				mul_a = ady;
				mul_b = ady;
			end
			ST_SQR: begin
				mul_a = ghost_radius_q;
				mul_b = ghost_radius_q;
			end
			default: begin
				mul_a = map_raw - map_lo;
				mul_b = map_smax;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// shared divider operands
	always_comb begin
		case (state_q)
			ST_ZDIV1: begin
				div_num = NUM_W'(z1_total);
				div_den = PRESS_DIV;
			end
			ST_ZDIV2: begin
				div_num = NUM_W'(z2_total);
				div_den = PRESS_DIV;
			end
			ST_XDIV, ST_YDIV: begin
				div_num = NUM_W'(kept);
				div_den = TRIM_DIV;
			end
			default: begin
				div_num = prod_q;
				div_den = map_hi - map_lo;
			end
		endcase
	end

	rtsf_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start_q),
		.num   (div_num),
		.den   (div_den),
		.busy  (div_busy),
		.done  (div_done),
		.quo   (div_quo)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACC;
			div_start_q <= 1'b0;
			axis_q      <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			case (state_q)
				ST_ACC: begin
					if (accept) begin
						if (pos_next == IDX_W'(Z2_END)) begin
							state_q     <= ST_ZDIV1;
							div_start_q <= 1'b1;
						end else if (pos_next == IDX_W'(X_END)) begin
							state_q     <= ST_XDIV;
							div_start_q <= 1'b1;
						end else if (pos_next == IDX_W'(Y_END)) begin
							state_q     <= ST_YDIV;
							div_start_q <= 1'b1;
						end
					end
				end
				ST_ZDIV1: begin
					if (div_done) begin
						state_q     <= ST_ZDIV2;
						div_start_q <= 1'b1;
					end
				end
				ST_ZDIV2: begin
					if (div_done) state_q <= ST_GATE;
				end
				ST_GATE: begin
					state_q <= (gate_q < thr_q) ? ST_EMIT : ST_ACC;
				end
				ST_XDIV: begin
					if (div_done) state_q <= ST_ACC;
				end
				ST_YDIV: begin
					if (div_done) begin
						axis_q <= 1'b0;
						if (orient_q[rtsf_pkg::OR_RAW]) begin
							state_q <= ST_EMIT;
						end else if (ghost_radius_q != '0) begin
							state_q <= ST_SQX;
						end else begin
							state_q <= ST_MAP;
						end
					end
				end
				ST_SQX: state_q <= ST_SQY;
				ST_SQY: state_q <= ST_SQR;
				ST_SQR: state_q <= ST_CMP;
				ST_CMP: begin
					state_q <= (sq_sum_q < {1'b0, prod_q}) ? ST_EMIT : ST_MAP;
				end
				ST_MAP: begin
					if (map_le_lo || map_ge_hi) begin
						if (!axis_q) begin
							axis_q <= 1'b1;
						end else begin
							state_q <= ST_EMIT;
						end
					end else begin
						// product settles this cycle, divide starts next
						state_q     <= ST_MAPDIV;
						div_start_q <= 1'b1;
					end
				end
				ST_MAPDIV: begin
					if (div_done) begin
						if (!axis_q) begin
							axis_q  <= 1'b1;
							state_q <= ST_MAP;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (load_out) state_q <= ST_ACC;
				end
				default: state_q <= ST_ACC;
			endcase
		end
	end

	// sequencer payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_ZDIV1: begin
				if (div_done) avg1_q <= quo_s;
			end
			ST_ZDIV2: begin
				if (div_done) begin
					gate_q <= {1'b0, avg1_q} + {1'b0, rtsf_pkg::FULL_SCALE} - {1'b0, quo_s};
				end
			end
			ST_GATE: begin
				res_touched_q <= 1'b0;
				res_outcome_q <= rtsf_pkg::OUT_LOW;
				res_x_q       <= '0;
				res_y_q       <= '0;
			end
			ST_XDIV: begin
				if (div_done) x_avg_q <= quo_s;
			end
			ST_YDIV: begin
				if (div_done) begin
					y_avg_q       <= quo_s;
					// raw mode result; overwritten on the other paths
					res_touched_q <= 1'b1;
					res_outcome_q <= rtsf_pkg::OUT_TOUCH;
					res_x_q       <= x_avg_q;
					res_y_q       <= quo_s;
				end
			end
			ST_SQY: sq_sum_q <= {1'b0, prod_q};
			ST_SQR: sq_sum_q <= sq_sum_q + {1'b0, prod_q};
			ST_CMP: begin
				if (sq_sum_q < {1'b0, prod_q}) begin
					res_touched_q <= 1'b0;
					res_outcome_q <= rtsf_pkg::OUT_GHOST;
					res_x_q       <= '0;
					res_y_q       <= '0;
				end
			end
			ST_MAP, ST_MAPDIV: begin
				if ((state_q == ST_MAPDIV) ? div_done : (map_le_lo || map_ge_hi)) begin
					res_touched_q <= 1'b1;
					res_outcome_q <= rtsf_pkg::OUT_TOUCH;
					if (!axis_q) begin
						res_x_q <= map_out;
					end else begin
						res_y_q <= map_out;
					end
				end
			end
			default: ;
		endcase
	end

	// output register: loads when empty or being drained this cycle
	assign load_out = (state_q == ST_EMIT) && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_touched_q <= res_touched_q;
			out_outcome_q <= res_outcome_q;
			out_x_q       <= res_x_q;
			out_y_q       <= res_y_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_y_q, out_x_q};
	assign m_tuser  = {out_outcome_q, out_touched_q};

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx <= IDX_W'(Y_END))
		else $error("sample index past end of frame");

	a_no_touch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
		else $error("no-touch result carries a position");

	a_frame_end_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (pos_next == IDX_W'(Y_END))) |=> !s_tready)
		else $error("sampling continued past frame end");

	a_ready_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !div_busy)
		else $error("sampling while divider busy");

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

// Sample stream in, touch reports out. Frames of Z1/Z2/X/Y conversions are
// queued by the stimulus process. The driver feeds them to the block and
// updates a local copy of the filter state on every accepted transfer.
// The monitor checks each result transfer against the oldest predicted report.
module testbench;
	import rtsf_pkg::*;

	localparam int SAMPLES_PER_AXIS = 30;
	localparam int PRESSURE_READS   = 4;
	localparam int SCREEN_WIDTH     = 320;
	localparam int SCREEN_HEIGHT    = 240;

	// frame layout, counted in accepted samples
	localparam int Z1_END = PRESSURE_READS;
	localparam int Z2_END = 2 * PRESSURE_READS;
	localparam int X_END  = Z2_END + SAMPLES_PER_AXIS;
	localparam int Y_END  = X_END + SAMPLES_PER_AXIS;

	localparam int ITEM_TARGET   = 1050;
	localparam int RESULT_TARGET = 48;
	// time for the worst phase-end processing to finish; leave plenty of margin
	localparam int DRAIN_CYCLES  = 200;
	localparam int CYCLE_LIMIT   = 600000;

	typedef struct packed {
		logic                 touched;
		logic [OUTCOME_W-1:0] outcome;
		logic [SAMPLE_W-1:0]  pos_x;
		logic [SAMPLE_W-1:0]  pos_y;
	} touch_result_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [15:0]          s_tdata   = '0;   // [11:0] adc_sample
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [23:0]          m_tdata;          // [11:0] pos_x, [23:12] pos_y
	logic [2:0]           m_tuser;          // [0] touched, [2:1] outcome
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;

	resistive_touch_sample_filter #(
		.SAMPLES_PER_AXIS(SAMPLES_PER_AXIS),
		.PRESSURE_READS(PRESSURE_READS),
		.SCREEN_WIDTH(SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// ---------------------------------------------------------------------
	// Local copy of the registers and of the frame accumulators
	// ---------------------------------------------------------------------
	logic [SAMPLE_W-1:0] cal_xl      = CAL_LOW_RST;
	logic [SAMPLE_W-1:0] cal_xh      = CAL_HIGH_RST;
	logic [SAMPLE_W-1:0] cal_yl      = CAL_LOW_RST;
	logic [SAMPLE_W-1:0] cal_yh      = CAL_HIGH_RST;
	logic [23:0]         null_center = '0;
	logic [SAMPLE_W-1:0] null_radius = '0;
	logic [THR_W-1:0]    press_thr   = THR_RST;
	logic [3:0]          orient      = '0;

	logic [6:0]          frame_pos = '0;
	logic [13:0]         z1_sum    = '0;
	logic [13:0]         z2_sum    = '0;
	logic [16:0]         axis_sum  = '0;
	logic [SAMPLE_W-1:0] axis_min  = FULL_SCALE;
	logic [SAMPLE_W-1:0] axis_max  = '0;
	logic [SAMPLE_W-1:0] x_mean    = '0;

	logic [SAMPLE_W-1:0] adc_q[$];        // samples not yet handed to the driver
	touch_result_t       expected_q[$];   // predicted reports, oldest first

	int items_queued   = 0;
	int samples_taken  = 0;
	int results_seen   = 0;
	int touches        = 0;
	int lows           = 0;
	int ghosts         = 0;
	int mismatches     = 0;
	int settings_used  = 0;
	int send_gap       = 0;
	int send_calm      = 0;
	int stall_left     = 0;
	int stall_calm     = 0;
	int cycle_count    = 0;

	function automatic void clear_axis();
		axis_sum = '0;
		axis_min = FULL_SCALE;
		axis_max = '0;
	endfunction

	// one min and one max dropped, remainder averaged, truncated
	function automatic logic [SAMPLE_W-1:0] trimmed_mean();
		return SAMPLE_W'((axis_sum - axis_min - axis_max) / (SAMPLES_PER_AXIS - 2));
	endfunction

	// clamped linear map; high <= low falls out as a step at low
	function automatic logic [SAMPLE_W-1:0] to_screen(logic [SAMPLE_W-1:0] raw,
			logic [SAMPLE_W-1:0] lo, logic [SAMPLE_W-1:0] hi, int unsigned last);
		if (raw <= lo)
			return '0;
		if (raw >= hi)
			return SAMPLE_W'(last);
		return SAMPLE_W'((32'(raw - lo) * last) / 32'(hi - lo));
	endfunction

	// advance the filter by one accepted conversion, queue any report it causes
	task automatic take_sample(input logic [SAMPLE_W-1:0] value);
		touch_result_t       res;
		int unsigned         gate;
		logic [SAMPLE_W-1:0] rx, ry, mx, my, px, py;
		longint              dx, dy, r;
		if (frame_pos < Z1_END)
			z1_sum += value;
		else if (frame_pos < Z2_END)
			z2_sum += value;
		else begin
			axis_sum += value;
			if (value < axis_min)
				axis_min = value;
			if (value > axis_max)
				axis_max = value;
		end
		frame_pos++;
		res = '0;
		if (frame_pos == Z2_END) begin
			// pressure gate: avg(Z1) + full scale - avg(Z2)
			gate = z1_sum / PRESSURE_READS + FULL_SCALE - z2_sum / PRESSURE_READS;
			z1_sum = '0;
			z2_sum = '0;
			clear_axis();
			if (gate < press_thr) begin
				frame_pos = '0;
				res.outcome = OUT_LOW;
				expected_q.push_back(res);
			end
		end else if (frame_pos == X_END) begin
			x_mean = trimmed_mean();
			clear_axis();
		end else if (frame_pos == Y_END) begin
			rx = x_mean;
			ry = trimmed_mean();
			clear_axis();
			frame_pos = '0;
			dx = longint'(rx) - longint'(null_center[11:0]);
			dy = longint'(ry) - longint'(null_center[23:12]);
			r = longint'(null_radius);
			if (orient[OR_RAW]) begin
				// raw mode bypasses null zone, swap, mapping and inversion
				res.touched = 1'b1;
				res.outcome = OUT_TOUCH;
				res.pos_x = rx;
				res.pos_y = ry;
			end else if (r != 0 && dx * dx + dy * dy < r * r) begin
				res.outcome = OUT_GHOST;
			end else begin
				// swap exchanges axes and calibration pairs, not screen sizes
				mx = orient[OR_SWAP] ? ry : rx;
				my = orient[OR_SWAP] ? rx : ry;
				px = orient[OR_SWAP] ? to_screen(mx, cal_yl, cal_yh, SCREEN_WIDTH - 1)
				                     : to_screen(mx, cal_xl, cal_xh, SCREEN_WIDTH - 1);
				py = orient[OR_SWAP] ? to_screen(my, cal_xl, cal_xh, SCREEN_HEIGHT - 1)
				                     : to_screen(my, cal_yl, cal_yh, SCREEN_HEIGHT - 1);
				if (orient[OR_INV_X])
					px = SAMPLE_W'(SCREEN_WIDTH - 1) - px;
				if (orient[OR_INV_Y])
					py = SAMPLE_W'(SCREEN_HEIGHT - 1) - py;
				res.touched = 1'b1;
				res.outcome = OUT_TOUCH;
				res.pos_x = px;
				res.pos_y = py;
			end
			expected_q.push_back(res);
		end
	endtask

	// mostly no gap or a short one, now and then a long one, and calm stretches
	function automatic int pick_gap(inout int calm);
		int roll;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 2)
			calm = $urandom_range(40, 200);
		if (roll < 55)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// ---------------------------------------------------------------------
	// Sample driver: one transfer per handshake, random gaps between them
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				take_sample(s_tdata[SAMPLE_W-1:0]);
				samples_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (adc_q.size() > 0) begin
					s_tdata <= {4'b0, adc_q.pop_front()};
					s_tvalid <= 1'b1;
					send_gap = pick_gap(send_calm);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Result monitor with random backpressure
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : watch_results
		touch_result_t want;
		if (m_tvalid && m_tready) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				$error("unexpected result: touched %0d outcome %0d pos_x %0d pos_y %0d",
					m_tuser[0], m_tuser[2:1], m_tdata[11:0], m_tdata[23:12]);
				mismatches++;
			end else begin
				want = expected_q.pop_front();
				case (want.outcome)
					OUT_TOUCH: touches++;
					OUT_LOW:   lows++;
					OUT_GHOST: ghosts++;
					default: ;
				endcase
				if (m_tuser[0] !== want.touched) begin
					$error("touched: expected %0d, got %0d", want.touched, m_tuser[0]);
					mismatches++;
				end
				if (m_tuser[2:1] !== want.outcome) begin
					$error("outcome: expected %0d, got %0d", want.outcome, m_tuser[2:1]);
					mismatches++;
				end
				if (m_tdata[11:0] !== want.pos_x) begin
					$error("pos_x: expected %0d, got %0d", want.pos_x, m_tdata[11:0]);
					mismatches++;
				end
				if (m_tdata[23:12] !== want.pos_y) begin
					$error("pos_y: expected %0d, got %0d", want.pos_y, m_tdata[23:12]);
					mismatches++;
				end
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			stall_left = pick_gap(stall_calm);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Register writes; junk above each register's width must be dropped
	// ---------------------------------------------------------------------
	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		logic [CFG_W-1:0] keep;
		case (idx)
			REG_GHOST_CENTER: keep = 24'hFFFFFF;
			REG_PRESS_THR:    keep = 24'h001FFF;
			REG_ORIENT:       keep = 24'h00000F;
			default:          keep = 24'h000FFF;
		endcase
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= (value & keep) | (CFG_W'($urandom) & ~keep);
		@(posedge clk);
		case (idx)
			REG_CAL_X_LOW:    cal_xl = value[11:0];
			REG_CAL_X_HIGH:   cal_xh = value[11:0];
			REG_CAL_Y_LOW:    cal_yl = value[11:0];
			REG_CAL_Y_HIGH:   cal_yh = value[11:0];
			REG_GHOST_CENTER: null_center = value;
			REG_GHOST_RADIUS: null_radius = value[11:0];
			REG_PRESS_THR:    press_thr = value[12:0];
			REG_ORIENT:       orient = value[3:0];
			default: ;
		endcase
	endtask

	// called only while idle, right after wait_idle returns
	task automatic write_config(input int xl, input int xh, input int yl, input int yh,
			input int center, input int radius, input int thr, input int flags);
		set_reg(REG_CAL_X_LOW, CFG_W'(xl));
		set_reg(REG_CAL_X_HIGH, CFG_W'(xh));
		set_reg(REG_CAL_Y_LOW, CFG_W'(yl));
		set_reg(REG_CAL_Y_HIGH, CFG_W'(yh));
		set_reg(REG_GHOST_CENTER, CFG_W'(center));
		set_reg(REG_GHOST_RADIUS, CFG_W'(radius));
		set_reg(REG_PRESS_THR, CFG_W'(thr));
		set_reg(REG_ORIENT, CFG_W'(flags));
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// every queued sample taken, every report in, then let the datapath settle
	task automatic wait_idle();
		do
			@(posedge clk);
		while (samples_taken != items_queued || expected_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// ---------------------------------------------------------------------
	// Frame builders
	// ---------------------------------------------------------------------
	task automatic queue_sample(input logic [SAMPLE_W-1:0] value);
		adc_q.push_back(value);
		items_queued++;
	endtask

	function automatic logic [SAMPLE_W-1:0] jitter(int center, int spread);
		int v;
		v = center + $urandom_range(0, 2 * spread) - spread;
		if (v < 0)
			v = 0;
		if (v > FULL_SCALE)
			v = FULL_SCALE;
		return SAMPLE_W'(v);
	endfunction

	task automatic push_pressure(input int a_lo, input int a_hi, input int b_lo, input int b_hi);
		repeat (PRESSURE_READS) queue_sample(SAMPLE_W'($urandom_range(a_lo, a_hi)));
		repeat (PRESSURE_READS) queue_sample(SAMPLE_W'($urandom_range(b_lo, b_hi)));
	endtask

	// one axis burst; outliers plant a zero and, unless both pick one slot, a full-scale reading to be trimmed
	task automatic push_axis(input int center, input int spread, input bit outliers);
		int hot, cold;
		hot = outliers ? $urandom_range(0, SAMPLES_PER_AXIS - 1) : -1;
		cold = outliers ? $urandom_range(0, SAMPLES_PER_AXIS - 1) : -1;
		for (int i = 0; i < SAMPLES_PER_AXIS; i++) begin
			if (i == cold)
				queue_sample('0);
			else if (i == hot)
				queue_sample(FULL_SCALE);
			else
				queue_sample(jitter(center, spread));
		end
	endtask

	function automatic int pick_cal(bit upper);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 10)
			return upper ? FULL_SCALE : 0;
		if (roll < 15)
			return upper ? 0 : FULL_SCALE;
		if (roll < 22)
			return $urandom_range(0, FULL_SCALE);
		return upper ? $urandom_range(2800, FULL_SCALE) : $urandom_range(0, 1200);
	endfunction

	// ---------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------
	initial begin
		int roll, spread, target, a, b, radius, thr;
		int cx, cy;
		bit outl;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: full-scale pressure, X pinned low, Y pinned high
		push_pressure(FULL_SCALE, FULL_SCALE, 0, 0);
		push_axis(0, 0, 0);
		push_axis(FULL_SCALE, 0, 0);
		// no pressure at all
		push_pressure(0, 0, FULL_SCALE, FULL_SCALE);
		// gate exactly at the threshold passes, one below fails
		push_pressure(THR_RST, THR_RST, FULL_SCALE, FULL_SCALE);
		push_axis(2048, 30, 1);
		push_axis(1000, 30, 1);
		push_pressure(THR_RST - 1, THR_RST - 1, FULL_SCALE, FULL_SCALE);
		wait_idle();

		// raw mode ignores the null zone even when the point sits inside it
		write_config(200, 3900, 200, 3900, (100 << 12) | 100, 50, 0, 1 << OR_RAW);
		push_pressure(0, 0, FULL_SCALE, FULL_SCALE);
		push_axis(100, 0, 0);
		push_axis(100, 0, 0);
		push_pressure(2048, FULL_SCALE, 0, 2047);
		push_axis(2048, 2047, 1);
		push_axis(2048, 2047, 1);
		wait_idle();

		// swap plus both inversions, reversed X calibration, null zone at mid-scale
		write_config(FULL_SCALE, 0, 0, FULL_SCALE, (2048 << 12) | 2048, 100, THR_RST,
			(1 << OR_SWAP) | (1 << OR_INV_X) | (1 << OR_INV_Y));
		push_pressure(2048, FULL_SCALE, 0, 2047);
		push_axis(2048, 0, 0);
		push_axis(2048, 0, 0);
		// exactly on the radius: not rejected
		push_pressure(2048, FULL_SCALE, 0, 2047);
		push_axis(2148, 0, 0);
		push_axis(2048, 0, 0);
		// just inside
		push_pressure(2048, FULL_SCALE, 0, 2047);
		push_axis(2048, 0, 0);
		push_axis(2147, 0, 0);
		wait_idle();

		// top threshold: nothing can pass
		write_config(2048, 2048, FULL_SCALE, FULL_SCALE, 24'hFFFFFF, FULL_SCALE, 8191,
			1 << OR_INV_X);
		push_pressure(FULL_SCALE, FULL_SCALE, 0, 0);
		wait_idle();

		// widest null zone at the origin, degenerate calibration on both axes
		write_config(2048, 2048, 0, 0, 0, FULL_SCALE, 0, (1 << OR_INV_X) | (1 << OR_INV_Y));
		push_pressure(FULL_SCALE, FULL_SCALE, 0, 0);
		push_axis(FULL_SCALE, 0, 0);
		push_axis(FULL_SCALE, 0, 0);
		push_pressure(FULL_SCALE, FULL_SCALE, 0, 0);
		push_axis(0, 0, 0);
		push_axis(FULL_SCALE, 0, 0);
		push_pressure(FULL_SCALE, FULL_SCALE, 0, 0);
		push_axis(100, 0, 0);
		push_axis(100, 0, 0);
		wait_idle();

		// random settings, each followed by a handful of frames
		while (items_queued < ITEM_TARGET || results_seen < RESULT_TARGET) begin
			roll = $urandom_range(0, 99);
			radius = roll < 40 ? 0 : roll < 80 ? $urandom_range(1, 600) :
				roll < 90 ? FULL_SCALE : $urandom_range(0, FULL_SCALE);
			roll = $urandom_range(0, 99);
			thr = roll < 50 ? $urandom_range(0, 3000) : roll < 65 ? 0 :
				roll < 75 ? 8191 : $urandom_range(0, 8191);
			write_config(pick_cal(0), pick_cal(1), pick_cal(0), pick_cal(1),
				$urandom_range(0, 24'hFFFFFF), radius, thr, $urandom_range(0, 15));
			repeat ($urandom_range(2, 6)) begin
				roll = $urandom_range(0, 99);
				if (roll < 60) begin
					// well-formed touch, sometimes aimed at the null zone
					if (null_radius != 0 && $urandom_range(0, 9) < 4) begin
						cx = jitter(null_center[11:0], null_radius);
						cy = jitter(null_center[23:12], null_radius);
					end else begin
						cx = $urandom_range(0, FULL_SCALE);
						cy = $urandom_range(0, FULL_SCALE);
					end
					roll = $urandom_range(0, 9);
					spread = roll < 2 ? 0 : roll < 9 ? $urandom_range(1, 40) : 2047;
					outl = $urandom_range(0, 1);
					push_pressure(2048, FULL_SCALE, 0, 2047);
					push_axis(cx, spread, outl);
					push_axis(cy, spread, outl);
				end else if (roll < 72) begin
					// light press; if it still passes, the frame is left short
					push_pressure(0, 1023, 3072, FULL_SCALE);
				end else if (roll < 82) begin
					// gate placed at or one below the threshold
					target = int'(press_thr) - $urandom_range(0, 1);
					if (target < 0)
						target = 0;
					if (target > 2 * FULL_SCALE)
						target = 2 * FULL_SCALE;
					a = target >= FULL_SCALE ? target - FULL_SCALE : 0;
					b = a + FULL_SCALE - target;
					push_pressure(a, a, b, b);
					push_axis($urandom_range(0, FULL_SCALE), 20, 1);
					push_axis($urandom_range(0, FULL_SCALE), 20, 1);
				end else if (roll < 92) begin
					repeat (Y_END) queue_sample(SAMPLE_W'($urandom));
				end else begin
					// stray samples knock the frame alignment off
					repeat ($urandom_range(1, 40)) queue_sample(SAMPLE_W'($urandom));
				end
			end
			wait_idle();
		end

		$display("Run covered %0d samples under %0d register settings.",
			samples_taken, settings_used);
		$display("Reports: %0d positions, %0d low pressure, %0d in null zone.",
			touches, lows, ghosts);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/rtsf_pkg.sv
rtl/rtsf_accum.sv
rtl/rtsf_div.sv
rtl/resistive_touch_sample_filter.sv
test/testbench.sv
